### rtl/mzsd_pkg.sv
// ----------------------------------------------------------------------------
// mzsd_pkg: shared types and constants
// Constants, register codes and controller/datapath bundles for the
// minimum z-normalized shapelet distance block.
// ----------------------------------------------------------------------------
package mzsd_pkg;

    // default store depths
    localparam int MAX_SHAPELET_DEF = 256;
    localparam int MAX_SERIES_DEF   = 1024;

    // field widths
    localparam int SAMPLE_W   = 16;
    localparam int DIST_W     = 18;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int SHL_W      = 9;
    localparam int SEL_W      = 11;
    localparam int BEST_W     = 32;
    localparam int ROOT_W     = 32;
    localparam int SHIFT_W    = 6;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SHAPELET_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SERIES_LENGTH   = 2'd1;

    // register reset values
    localparam logic [SHL_W-1:0] SHL_RESET = 9'd16;
    localparam logic [SEL_W-1:0] SEL_RESET = 11'd128;

    // fixed-point constants
    localparam logic [BEST_W-1:0] ONE_Q30  = 32'h4000_0000;
    localparam logic [DIST_W-1:0] DIST_SAT = 18'h2_0000;

    // product pair selection
    typedef enum logic [1:0] {
        MUL_VY,
        MUL_VX,
        MUL_N
    } t_mul_op;

    // controller states
    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_VY_MUL,
        S_VY_SUB,
        S_VY_CHK,
        S_VY_SQ,
        S_VY_SQW,
        S_WIN,
        S_MAC,
        S_DRAIN,
        S_VX_MUL,
        S_VX_SUB,
        S_VX_CHK,
        S_VX_SQ,
        S_VX_SQW,
        S_N_MUL,
        S_N_SUB,
        S_P_MUL,
        S_DIV,
        S_DIV_W,
        S_UPDATE,
        S_NEXT,
        S_FIN_SQ,
        S_FIN_SQW,
        S_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic    clr_row;
        logic    set_nowin;
        logic    set_degen;
        logic    mul_en;
        t_mul_op mul_op;
        logic    sub_en;
        logic    sq_start;
        logic    sq_final;
        logic    ld_sy;
        logic    clr_j;
        logic    inc_j;
        logic    win_clr;
        logic    mac_issue;
        logic    p_en;
        logic    div_start;
        logic    upd_en;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic row_end;
        logic no_win;
        logic incomplete;
        logic diff_zero;
        logic sq_busy;
        logic sq_done;
        logic div_busy;
        logic div_done;
        logic mac_busy;
        logic last_k;
        logic last_j;
    } t_dp_stat;

endpackage

### rtl/mzsd_sqrt.sv
// ----------------------------------------------------------------------------
// mzsd_sqrt: iterative normalized square root
// Optionally shifts the operand left two bits a cycle until it reaches
// 2^60, then takes the floor square root one result bit per cycle.
// ----------------------------------------------------------------------------
module mzsd_sqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_norm,
    input  logic [63:0]                  i_value,
    output logic                         o_busy,
    output logic                         o_done,
    output logic [mzsd_pkg::ROOT_W-1:0]  o_root,
    output logic [mzsd_pkg::SHIFT_W-1:0] o_shift
);
    import mzsd_pkg::*;

    logic                r_run;
    logic                r_norm;
    logic                r_done;
    logic [63:0]         r_v;
    logic [63:0]         r_r;
    logic [63:0]         r_bit;
    logic [4:0]          r_cnt;
    logic [SHIFT_W-1:0]  r_sh;
    logic [63:0]         sq_trial;

    assign sq_trial = r_r + r_bit;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_norm <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run  <= 1'b1;
                r_norm <= i_norm;
            end else if (r_run && r_norm) begin
                if (r_v[63:60] != 4'd0) begin
                    r_norm <= 1'b0;
                end
            end else if (r_run && (r_cnt == 5'd31)) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // normalize, then one root bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_value;
            r_r   <= '0;
            r_bit <= 64'h4000_0000_0000_0000;
            r_cnt <= '0;
            r_sh  <= '0;
        end else if (r_run && r_norm) begin
            if (r_v[63:60] == 4'd0) begin
                r_v  <= r_v << 2;
                r_sh <= r_sh + SHIFT_W'(1);
            end
        end else if (r_run) begin
            if (r_v >= sq_trial) begin
                r_v <= r_v - sq_trial;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
            r_cnt <= r_cnt + 5'd1;
        end
    end

    assign o_busy  = r_run;
    assign o_done  = r_done;
    assign o_root  = r_r[ROOT_W-1:0];
    assign o_shift = r_sh;

endmodule

### rtl/mzsd_div.sv
// ----------------------------------------------------------------------------
// mzsd_div: restoring divider
// 64-bit dividend by 31-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mzsd_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_busy,
    output logic        o_done,
    output logic [63:0] o_quot
);
    logic        r_run;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [63:0] r_q;
    logic [31:0] r_rem;
    logic [31:0] r_d;
    logic [31:0] trial;
    logic        fits;

    // remainder stays below the divisor, so the shifted value fits 32 bits
    assign trial = {r_rem[30:0], r_q[63]};
    assign fits  = trial >= r_d;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run && (r_cnt == 6'd63)) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // shift-subtract step
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_d   <= i_divisor;
            r_cnt <= '0;
        end else if (r_run) begin
            r_rem <= fits ? (trial - r_d) : trial;
            r_q   <= {r_q[62:0], fits};
            r_cnt <= r_cnt + 6'd1;
        end
    end

    assign o_busy = r_run;
    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

### rtl/mzsd_datapath.sv
// ----------------------------------------------------------------------------
// mzsd_datapath: stores, sums and arithmetic units
// Holds the sample stores, the shapelet statistics, the window MAC, the
// variance and covariance products, and the root and divide units.
// ----------------------------------------------------------------------------
module mzsd_datapath #(
    parameter int MAX_SHAPELET = mzsd_pkg::MAX_SHAPELET_DEF,
    parameter int MAX_SERIES   = mzsd_pkg::MAX_SERIES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_acc,
    input  logic                            i_func,
    input  logic signed [15:0]              i_sample,
    input  logic                            i_cfg_we,
    input  logic [mzsd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mzsd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  mzsd_pkg::t_dp_cmd               i_cmd,
    output mzsd_pkg::t_dp_stat              o_stat,
    output logic [mzsd_pkg::DIST_W-1:0]     o_distance,
    output logic                            o_no_window,
    output logic                            o_degenerate
);
    import mzsd_pkg::*;

    localparam int LW     = $clog2(MAX_SHAPELET + 1);
    localparam int LSW    = $clog2(MAX_SERIES + 1);
    localparam int LSW1   = LSW + 1;
    localparam int SHA_AW = $clog2(MAX_SHAPELET);
    localparam int SER_AW = $clog2(MAX_SERIES);
    localparam int SER_AW1 = SER_AW + 1;
    localparam int SW     = SAMPLE_W + LW;
    localparam int QW     = 2 * SAMPLE_W - 2 + LW;
    localparam int XYW    = 2 * SAMPLE_W - 1 + LW;
    localparam int B1W    = XYW + 1;
    localparam int M1W    = LW + 1 + B1W;
    localparam int M2W    = 2 * SW;
    localparam int PW     = LW + B1W + 2;

    // configuration and load state
    logic [SHL_W-1:0]        r_cfg_l;
    logic [SEL_W-1:0]        r_cfg_ls;
    logic [LW-1:0]           r_sh_cnt;
    logic signed [SW-1:0]    r_sh_sum;
    logic [QW-1:0]           r_sh_sq;
    logic [LSW-1:0]          r_ser_cnt;
    logic [BEST_W-1:0]       r_best;
    logic                    r_no_win;
    logic                    r_degen;

    logic [LW-1:0]           eff_l;
    logic [LSW-1:0]          eff_ls;

    // memories
    logic [SAMPLE_W-1:0]     r_sh_mem [MAX_SHAPELET];
    logic [SAMPLE_W-1:0]     r_ser_mem [MAX_SERIES];
    logic [SAMPLE_W-1:0]     r_rd_x;
    logic [SAMPLE_W-1:0]     r_rd_y;

    // load path
    logic                         sh_restart;
    logic [LW-1:0]                sh_base;
    logic signed [2*SAMPLE_W-1:0] samp_sq;
    logic                         ser_restart;
    logic [LSW-1:0]               ser_base;
    logic [LSW1-1:0]              ser_next;
    logic                         row_end;

    // window MAC
    logic [SHA_AW-1:0]            r_k;
    logic [SER_AW-1:0]            r_j;
    logic [SER_AW1-1:0]           ser_raddr;
    logic                         r_mv0;
    logic                         r_mv1;
    logic signed [SAMPLE_W-1:0]   r_x;
    logic signed [2*SAMPLE_W-1:0] r_pxx;
    logic signed [2*SAMPLE_W-1:0] r_pxy;
    logic signed [SW-1:0]         r_sx;
    logic [QW-1:0]                r_sxx;
    logic signed [XYW-1:0]        r_sxy;

    // products
    logic signed [B1W-1:0]   b1;
    logic signed [SW-1:0]    a2;
    logic signed [SW-1:0]    b2;
    logic signed [M1W-1:0]   m1;
    logic signed [M2W-1:0]   m2;
    logic signed [PW-1:0]    r_pa;
    logic signed [PW-1:0]    r_pb;
    logic signed [PW-1:0]    r_diff;

    // root, scale and divide
    logic                    sq_busy;
    logic                    sq_done;
    logic [ROOT_W-1:0]       sq_root;
    logic [SHIFT_W-1:0]      sq_shift;
    logic [63:0]             sq_value;
    logic [ROOT_W-1:0]       r_sy;
    logic [SHIFT_W-1:0]      r_b;
    logic [63:0]             prod_p;
    logic [31:0]             r_p;
    logic [63:0]             r_mag;
    logic                    r_neg;
    logic [PW-1:0]           abs_n;
    logic [SHIFT_W:0]        e_sum;
    logic [63:0]             mag64;
    logic [63:0]             mag_sh;
    logic                    div_busy;
    logic                    div_done;
    logic [63:0]             div_quot;
    logic [BEST_W-1:0]       qc;
    logic [BEST_W-1:0]       dq;

    // effective lengths: zero taken as one, larger values clamped to the store depths
    always_comb begin
        if (r_cfg_l == '0) begin
            eff_l = LW'(1);
        end else if (32'(r_cfg_l) > MAX_SHAPELET) begin
            eff_l = LW'(MAX_SHAPELET);
        end else begin
            eff_l = LW'(r_cfg_l);
        end
        if (r_cfg_ls == '0) begin
            eff_ls = LSW'(1);
        end else if (32'(r_cfg_ls) > MAX_SERIES) begin
            eff_ls = LSW'(MAX_SERIES);
        end else begin
            eff_ls = LSW'(r_cfg_ls);
        end
    end

    // load bookkeeping
    assign sh_restart  = r_sh_cnt >= eff_l;
    assign sh_base     = sh_restart ? '0 : r_sh_cnt;
    assign samp_sq     = i_sample * i_sample;
    assign ser_restart = r_ser_cnt >= eff_ls;
    assign ser_base    = ser_restart ? '0 : r_ser_cnt;
    assign ser_next    = LSW1'(ser_base) + LSW1'(1);
    assign row_end     = i_func && (ser_next >= LSW1'(eff_ls));

    // registers, counts and shapelet sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_l   <= SHL_RESET;
            r_cfg_ls  <= SEL_RESET;
            r_sh_cnt  <= '0;
            r_sh_sum  <= '0;
            r_sh_sq   <= '0;
            r_ser_cnt <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SHAPELET_LENGTH: begin
                    r_cfg_l  <= i_cfg_data[SHL_W-1:0];
                    r_sh_cnt <= '0;
                    r_sh_sum <= '0;
                    r_sh_sq  <= '0;
                end
                REG_SERIES_LENGTH: begin
                    r_cfg_ls  <= i_cfg_data[SEL_W-1:0];
                    r_ser_cnt <= '0;
                end
                default: ;
            endcase
        end else if (i_acc) begin
            if (!i_func) begin
                r_sh_cnt <= sh_base + LW'(1);
                r_sh_sum <= (sh_restart ? SW'(0) : r_sh_sum) + SW'(i_sample);
                r_sh_sq  <= (sh_restart ? QW'(0) : r_sh_sq) + QW'($unsigned(samp_sq));
            end else begin
                r_ser_cnt <= row_end ? '0 : ser_next[LSW-1:0];
            end
        end
    end

    // shapelet store
    always_ff @(posedge i_clk) begin
        if (i_acc && !i_func) begin
            r_sh_mem[sh_base[SHA_AW-1:0]] <= i_sample;
        end
        r_rd_y <= r_sh_mem[r_k];
    end

    // series store, read at window offset plus tap
    assign ser_raddr = SER_AW1'(r_j) + SER_AW1'(r_k);

    always_ff @(posedge i_clk) begin
        if (i_acc && i_func) begin
            r_ser_mem[ser_base[SER_AW-1:0]] <= i_sample;
        end
        r_rd_x <= r_ser_mem[ser_raddr[SER_AW-1:0]];
    end

    // window and tap counters
    always_ff @(posedge i_clk) begin
        if (i_cmd.win_clr) begin
            r_k <= '0;
        end else if (i_cmd.mac_issue) begin
            r_k <= r_k + SHA_AW'(1);
        end
        if (i_cmd.clr_j) begin
            r_j <= '0;
        end else if (i_cmd.inc_j) begin
            r_j <= r_j + SER_AW'(1);
        end
    end

    // MAC pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv0 <= 1'b0;
            r_mv1 <= 1'b0;
        end else begin
            r_mv0 <= i_cmd.mac_issue;
            r_mv1 <= r_mv0;
        end
    end

    // products, then accumulate
    always_ff @(posedge i_clk) begin
        r_x   <= $signed(r_rd_x);
        r_pxx <= $signed(r_rd_x) * $signed(r_rd_x);
        r_pxy <= $signed(r_rd_x) * $signed(r_rd_y);
        if (i_cmd.win_clr) begin
            r_sx  <= '0;
            r_sxx <= '0;
            r_sxy <= '0;
        end else if (r_mv1) begin
            r_sx  <= r_sx + SW'(r_x);
            r_sxx <= r_sxx + QW'($unsigned(r_pxx));
            r_sxy <= r_sxy + XYW'(r_pxy);
        end
    end

    // operand selection for L*A - B*C
    always_comb begin
        case (i_cmd.mul_op)
            MUL_VY: begin
                b1 = $signed(B1W'(r_sh_sq));
                a2 = r_sh_sum;
                b2 = r_sh_sum;
            end
            MUL_VX: begin
                b1 = $signed(B1W'(r_sxx));
                a2 = r_sx;
                b2 = r_sx;
            end
            MUL_N: begin
                b1 = B1W'(r_sxy);
                a2 = r_sx;
                b2 = r_sh_sum;
            end
            default: begin
                b1 = '0;
                a2 = '0;
                b2 = '0;
            end
        endcase
    end

    assign m1 = $signed({1'b0, eff_l}) * b1;
    assign m2 = a2 * b2;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_pa <= PW'(m1);
            r_pb <= PW'(m2);
        end
        if (i_cmd.sub_en) begin
            r_diff <= r_pa - r_pb;
        end
    end

    // root unit: variances normalized, final distance plain
    assign sq_value = i_cmd.sq_final ? 64'({r_best, 3'b000}) : 64'($unsigned(r_diff));

    mzsd_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sq_start),
        .i_norm  (!i_cmd.sq_final),
        .i_value (sq_value),
        .o_busy  (sq_busy),
        .o_done  (sq_done),
        .o_root  (sq_root),
        .o_shift (sq_shift)
    );

    // scaled covariance magnitude and deviation product
    assign abs_n  = r_diff[PW-1] ? $unsigned(-r_diff) : $unsigned(r_diff);
    assign e_sum  = (SHIFT_W+1)'(sq_shift) + (SHIFT_W+1)'(r_b);
    assign mag64  = 64'(abs_n);
    assign mag_sh = (e_sum == '0) ? (mag64 >> 1) : (mag64 << (e_sum - (SHIFT_W+1)'(1)));
    assign prod_p = 64'(sq_root) * 64'(r_sy);

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_sy) begin
            r_sy <= sq_root;
            r_b  <= sq_shift;
        end
        if (i_cmd.p_en) begin
            r_p   <= prod_p[62:31];
            r_mag <= mag_sh;
            r_neg <= r_diff[PW-1];
        end
    end

    mzsd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_mag),
        .i_divisor  (r_p),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // correlation clamped to one, then 1 - r
    assign qc = (div_quot > 64'(ONE_Q30)) ? ONE_Q30 : div_quot[BEST_W-1:0];
    assign dq = r_neg ? (ONE_Q30 + qc) : (ONE_Q30 - qc);

    // running minimum and row flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best   <= '1;
            r_no_win <= 1'b0;
            r_degen  <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_index == REG_SERIES_LENGTH)) begin
                r_best <= '1;
            end else if (i_cmd.clr_row) begin
                r_best <= '1;
            end else if (i_cmd.upd_en && (dq < r_best)) begin
                r_best <= dq;
            end
            if (i_cmd.clr_row) begin
                r_no_win <= i_cmd.set_nowin;
                r_degen  <= i_cmd.set_degen;
            end else begin
                if (i_cmd.set_nowin) begin
                    r_no_win <= 1'b1;
                end
                if (i_cmd.set_degen) begin
                    r_degen <= 1'b1;
                end
            end
        end
    end

    // status
    assign o_stat.row_end    = row_end;
    assign o_stat.no_win     = 32'(eff_l) > 32'(eff_ls);
    assign o_stat.incomplete = r_sh_cnt != eff_l;
    assign o_stat.diff_zero  = r_diff == '0;
    assign o_stat.sq_busy    = sq_busy;
    assign o_stat.sq_done    = sq_done;
    assign o_stat.div_busy   = div_busy;
    assign o_stat.div_done   = div_done;
    assign o_stat.mac_busy   = r_mv0 || r_mv1;
    assign o_stat.last_k     = 32'(r_k) == (32'(eff_l) - 32'd1);
    assign o_stat.last_j     = (32'(r_j) + 32'(eff_l)) == 32'(eff_ls);

    // result beat
    assign o_distance   = (r_best == '1) ? DIST_SAT : sq_root[DIST_W-1:0];
    assign o_no_window  = r_no_win;
    assign o_degenerate = r_degen;

endmodule

### rtl/mzsd_ctrl.sv
// ----------------------------------------------------------------------------
// mzsd_ctrl: row-end sequencer
// Steps through the shapelet variance, each window's MAC pass, root,
// divide and minimum update, then the final root and the result beat.
// ----------------------------------------------------------------------------
module mzsd_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_acc,
    input  mzsd_pkg::t_dp_stat i_stat,
    output mzsd_pkg::t_dp_cmd  o_cmd,
    output logic               o_busy,
    output logic               o_valid
);
    import mzsd_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (i_acc && i_stat.row_end) n_state = S_CHECK;
            S_CHECK: begin
                if (i_stat.no_win || i_stat.incomplete) n_state = S_FIN_SQ;
                else n_state = S_VY_MUL;
            end
            S_VY_MUL:  n_state = S_VY_SUB;
            S_VY_SUB:  n_state = S_VY_CHK;
            S_VY_CHK:  n_state = i_stat.diff_zero ? S_FIN_SQ : S_VY_SQ;
            S_VY_SQ:   n_state = S_VY_SQW;
            S_VY_SQW:  if (i_stat.sq_done) n_state = S_WIN;
            S_WIN:     n_state = S_MAC;
            S_MAC:     if (i_stat.last_k) n_state = S_DRAIN;
            S_DRAIN:   if (!i_stat.mac_busy) n_state = S_VX_MUL;
            S_VX_MUL:  n_state = S_VX_SUB;
            S_VX_SUB:  n_state = S_VX_CHK;
            S_VX_CHK:  n_state = i_stat.diff_zero ? S_NEXT : S_VX_SQ;
            S_VX_SQ:   n_state = S_VX_SQW;
            S_VX_SQW:  if (i_stat.sq_done) n_state = S_N_MUL;
            S_N_MUL:   n_state = S_N_SUB;
            S_N_SUB:   n_state = S_P_MUL;
            S_P_MUL:   n_state = S_DIV;
            S_DIV:     n_state = S_DIV_W;
            S_DIV_W:   if (i_stat.div_done) n_state = S_UPDATE;
            S_UPDATE:  n_state = S_NEXT;
            S_NEXT:    n_state = i_stat.last_j ? S_FIN_SQ : S_WIN;
            S_FIN_SQ:  n_state = S_FIN_SQW;
            S_FIN_SQW: if (i_stat.sq_done) n_state = S_OUT;
            S_OUT:     n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd        = '0;
        o_cmd.mul_op = MUL_VY;
        o_valid      = 1'b0;
        unique case (r_state)
            S_CHECK: begin
                o_cmd.clr_row   = 1'b1;
                o_cmd.set_nowin = i_stat.no_win;
                o_cmd.set_degen = !i_stat.no_win && i_stat.incomplete;
            end
            S_VY_MUL: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = MUL_VY;
            end
            S_VY_SUB:  o_cmd.sub_en = 1'b1;
            S_VY_CHK:  o_cmd.set_degen = i_stat.diff_zero;
            S_VY_SQ:   o_cmd.sq_start = 1'b1;
            S_VY_SQW: begin
                o_cmd.ld_sy = i_stat.sq_done;
                o_cmd.clr_j = i_stat.sq_done;
            end
            S_WIN:     o_cmd.win_clr = 1'b1;
            S_MAC:     o_cmd.mac_issue = 1'b1;
            S_VX_MUL: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = MUL_VX;
            end
            S_VX_SUB:  o_cmd.sub_en = 1'b1;
            S_VX_CHK:  o_cmd.set_degen = i_stat.diff_zero;
            S_VX_SQ:   o_cmd.sq_start = 1'b1;
            S_N_MUL: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = MUL_N;
            end
            S_N_SUB:   o_cmd.sub_en = 1'b1;
            S_P_MUL:   o_cmd.p_en = 1'b1;
            S_DIV:     o_cmd.div_start = 1'b1;
            S_UPDATE:  o_cmd.upd_en = 1'b1;
            S_NEXT:    o_cmd.inc_j = !i_stat.last_j;
            S_FIN_SQ: begin
                o_cmd.sq_start = 1'b1;
                o_cmd.sq_final = 1'b1;
            end
            S_FIN_SQW: o_cmd.sq_final = 1'b1;
            S_OUT:     o_valid = 1'b1;
            default: ;
        endcase
    end

    assign o_busy = r_state != S_IDLE;

`ifndef SYNTH
    // the root unit is never restarted mid-operation
    a_sq_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.sq_start |-> !i_stat.sq_busy)
        else $error("root unit started while busy");

    // the divider is never restarted mid-operation
    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |-> !i_stat.div_busy)
        else $error("divider started while busy");

    // a row-ending sample always launches the sequence
    a_row_end_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_acc && i_stat.row_end) |=> o_busy)
        else $error("row end accepted without starting the sequence");
`endif

endmodule

### rtl/min_znorm_shapelet_distance.sv
// ----------------------------------------------------------------------------
// min_znorm_shapelet_distance: minimum z-normalized shapelet distance
// Loads a shapelet, then series rows; at each row end slides the shapelet
// over every window and emits sqrt(2*(1 - max correlation)) in Q2.16.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                    Payload
// item      in         start & !busy                i_func, i_sample
// result    out        o_valid (one-cycle strobe)   o_distance, o_no_window,
//                                                   o_degenerate
// config    in         i_cfg_valid & o_cfg_ready    i_cfg_index, i_cfg_data
//
// A sample that does not end a row is taken without raising busy. The
// row-ending sample holds busy while each of W = Ls - L + 1 windows goes
// through the shared MAC (one sample pair a cycle), the 64-step divider and
// the root unit (up to 30 normalize steps plus 32 root steps).
// Reset is synchronous, active low; stores need no clearing pass. Register
// writes wait while busy or start is high. The result beat cannot be stalled.
// ----------------------------------------------------------------------------
module min_znorm_shapelet_distance #(
    parameter int MAX_SHAPELET = mzsd_pkg::MAX_SHAPELET_DEF,
    parameter int MAX_SERIES   = mzsd_pkg::MAX_SERIES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_func,
    input  logic signed [15:0]              i_sample,
    output logic                            o_valid,
    output logic [mzsd_pkg::DIST_W-1:0]     o_distance,
    output logic                            o_no_window,
    output logic                            o_degenerate,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mzsd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mzsd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import mzsd_pkg::*;

    logic     acc;
    logic     cfg_we;
    t_dp_cmd  cmd;
    t_dp_stat stat;

    // register writes only when no row is in flight and no item is offered
    assign acc         = start && !busy;
    assign o_cfg_ready = !busy && !start;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    mzsd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    mzsd_datapath #(
        .MAX_SHAPELET (MAX_SHAPELET),
        .MAX_SERIES   (MAX_SERIES)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_acc        (acc),
        .i_func       (i_func),
        .i_sample     (i_sample),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_distance   (o_distance),
        .o_no_window  (o_no_window),
        .o_degenerate (o_degenerate)
    );

endmodule

### test/mzsd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mzsd_checker: result predictor and scoreboard
// Watches the item, config and result channels of the shapelet distance
// block, computes the expected distance and flags for every row end, and
// compares each result beat against the oldest expectation.
// ----------------------------------------------------------------------------
module mzsd_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic                            i_busy,
    input  logic                            i_func,
    input  logic signed [15:0]              i_sample,
    input  logic                            i_valid,
    input  logic [mzsd_pkg::DIST_W-1:0]     i_distance,
    input  logic                            i_no_window,
    input  logic                            i_degenerate,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [mzsd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mzsd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_errors,
    output int                              o_pending,
    output int                              o_rows
);
    import mzsd_pkg::*;

    localparam longint unsigned NO_BEST = 64'hFFFF_FFFF;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              no_window;
        logic              degenerate;
    } t_row_result;

    // predictor state
    logic signed [15:0] shp_mem [0:MAX_SHAPELET_DEF-1];
    logic signed [15:0] ser_mem [0:MAX_SERIES_DEF-1];
    longint             shp_sum;
    longint unsigned    shp_sum_sq;
    int                 shp_cnt;
    int                 ser_cnt;
    logic [SHL_W-1:0]   shl_reg;
    logic [SEL_W-1:0]   sel_reg;
    t_row_result        row_q[$];
    int                 errs;
    int                 rows;

    // floor square root, bit by bit
    function automatic longint unsigned root64(longint unsigned v);
        longint unsigned r = 0;
        longint unsigned b = 64'h1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // normalize to at least 2^60 by even shifts, then take the root
    function automatic longint unsigned norm_root(longint unsigned v, output int half_sh);
        half_sh = 0;
        while (v < (64'h1 << 60)) begin
            v <<= 2;
            half_sh++;
        end
        return root64(v);
    endfunction

    function automatic longint unsigned mag64(longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    // slide the shapelet over the stored row, keep the best (1 - r)
    function automatic t_row_result row_distance(int len, int slen);
        t_row_result     res;
        longint unsigned best;
        longint unsigned sy2, vy, sy, ax, vx, sxr, p, mag, q, dq;
        longint          sx, sxy, xv, n;
        longint unsigned sxx;
        int              b, a, e;
        res  = '0;
        best = NO_BEST;
        if (len > slen) begin
            res.no_window = 1'b1;
        end else if (shp_cnt != len) begin
            res.degenerate = 1'b1;
        end else begin
            sy2 = mag64(shp_sum);
            vy  = longint'(len) * shp_sum_sq - sy2 * sy2;
            if (vy == 0) begin
                res.degenerate = 1'b1;
            end else begin
                sy = norm_root(vy, b);
                for (int j = 0; j + len <= slen; j++) begin
                    sx  = 0;
                    sxy = 0;
                    sxx = 0;
                    for (int k = 0; k < len; k++) begin
                        xv  = longint'(ser_mem[j+k]);
                        sx  += xv;
                        sxx += longint'(xv * xv);
                        sxy += xv * longint'(shp_mem[k]);
                    end
                    ax = mag64(sx);
                    vx = longint'(len) * sxx - ax * ax;
                    if (vx == 0) begin
                        res.degenerate = 1'b1;
                        continue;
                    end
                    sxr = norm_root(vx, a);
                    p   = (sxr * sy) >> 31;
                    n   = longint'(len) * sxy - sx * shp_sum;
                    mag = mag64(n);
                    e   = a + b - 1;
                    if (e >= 0) mag = mag << e;
                    else mag = mag >> 1;
                    q = mag / p;
                    if (q > ONE_Q30) q = ONE_Q30;
                    dq = (n < 0) ? ONE_Q30 + q : ONE_Q30 - q;
                    if (dq < best) best = dq;
                end
            end
        end
        if (best == NO_BEST) res.distance = DIST_SAT;
        else res.distance = DIST_W'(root64(best << 3));
        return res;
    endfunction

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        errs++;
        $display("[%0t] mismatch on row %0d: %s got %0d, expected %0d",
                 $realtime, rows, what, got, want);
    endtask

    always @(posedge i_clk) begin
        int          len, slen;
        t_row_result want;
        if (!i_rst_n) begin
            shp_sum    = 0;
            shp_sum_sq = 0;
            shp_cnt    = 0;
            ser_cnt    = 0;
            shl_reg    = SHL_RESET;
            sel_reg    = SEL_RESET;
            errs       = 0;
            rows       = 0;
            row_q.delete();
            for (int i = 0; i < MAX_SHAPELET_DEF; i++) shp_mem[i] = '0;
            for (int i = 0; i < MAX_SERIES_DEF; i++) ser_mem[i] = '0;
        end else begin
            // result beat against oldest expectation
            if (i_valid) begin
                if (row_q.size() == 0) begin
                    flag_mismatch("unexpected result, distance", i_distance, -1);
                end else begin
                    want = row_q.pop_front();
                    if (i_distance !== want.distance)
                        flag_mismatch("distance", i_distance, want.distance);
                    if (i_no_window !== want.no_window)
                        flag_mismatch("no_window", i_no_window, want.no_window);
                    if (i_degenerate !== want.degenerate)
                        flag_mismatch("degenerate", i_degenerate, want.degenerate);
                end
                rows++;
            end
            // register writes
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_SHAPELET_LENGTH) begin
                    shl_reg    = i_cfg_data[SHL_W-1:0];
                    shp_cnt    = 0;
                    shp_sum    = 0;
                    shp_sum_sq = 0;
                end else if (i_cfg_index == REG_SERIES_LENGTH) begin
                    sel_reg = i_cfg_data;
                    ser_cnt = 0;
                end
            end
            // item beat
            if (i_start && !i_busy) begin
                len  = (shl_reg == 0) ? 1 : (shl_reg > MAX_SHAPELET_DEF) ? MAX_SHAPELET_DEF
                                                                         : int'(shl_reg);
                slen = (sel_reg == 0) ? 1 : (sel_reg > MAX_SERIES_DEF) ? MAX_SERIES_DEF
                                                                       : int'(sel_reg);
                if (!i_func) begin
                    if (shp_cnt >= len) begin
                        shp_cnt    = 0;
                        shp_sum    = 0;
                        shp_sum_sq = 0;
                    end
                    shp_mem[shp_cnt] = i_sample;
                    shp_sum    += longint'(i_sample);
                    shp_sum_sq += longint'(i_sample) * longint'(i_sample);
                    shp_cnt++;
                end else begin
                    if (ser_cnt >= slen) ser_cnt = 0;
                    ser_mem[ser_cnt] = i_sample;
                    ser_cnt++;
                    if (ser_cnt >= slen) begin
                        ser_cnt = 0;
                        row_q.push_back(row_distance(len, slen));
                    end
                end
            end
        end
        o_errors  <= errs;
        o_pending <= row_q.size();
        o_rows    <= rows;
    end

endmodule

### test/tb_min_znorm_shapelet_distance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_min_znorm_shapelet_distance: testbench top
// Drives shapelet loads, series rows and register writes into the block,
// with random sender gaps per phase; the checker predicts and scores every
// row-end result, and this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_min_znorm_shapelet_distance;
    import mzsd_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic                  i_func;
    logic signed [15:0]    i_sample;
    logic                  o_valid;
    logic [DIST_W-1:0]     o_distance;
    logic                  o_no_window;
    logic                  o_degenerate;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int errors, pending, rows_seen;
    int idle_pct;
    int beats_sent;
    int phase_cnt;
    logic signed [15:0] shp_vals [0:MAX_SHAPELET_DEF-1];
    int cur_len;

    min_znorm_shapelet_distance dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_func       (i_func),
        .i_sample     (i_sample),
        .o_valid      (o_valid),
        .o_distance   (o_distance),
        .o_no_window  (o_no_window),
        .o_degenerate (o_degenerate),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    mzsd_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_func       (i_func),
        .i_sample     (i_sample),
        .i_valid      (o_valid),
        .i_distance   (o_distance),
        .i_no_window  (o_no_window),
        .i_degenerate (o_degenerate),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_rows       (rows_seen)
    );

    // 12 ns clock
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // watchdog
    initial begin
        #30_000_000;
        $display("[min_znorm_shapelet_distance] ERROR");
        $finish;
    end

    // idle cycles at the current rate, then one item beat
    task automatic feed_sample(input logic f, input logic signed [15:0] s);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start    <= 1'b1;
        i_func   <= f;
        i_sample <= s;
        do @(posedge i_clk); while (busy);
        beats_sent++;
    endtask

    // hold off until every row result is back and the block is quiet
    task automatic drain();
        start <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending != 0 || busy) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_W'(data);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [15:0] pick_value(input int style);
        case (style)
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(0, 16)) - 8);
            default: return 16'($urandom_range(0, 3) * 16'h4000 + 16'h3FFF);
        endcase
    endfunction

    // style 0 full range, 1 small, 2 flat
    task automatic load_shapelet(input int n, input int style);
        logic signed [15:0] flat_v;
        flat_v = 16'($urandom);
        for (int k = 0; k < n; k++) begin
            shp_vals[k % MAX_SHAPELET_DEF] = (style == 2) ? flat_v : pick_value(style);
            feed_sample(1'b0, shp_vals[k % MAX_SHAPELET_DEF]);
        end
    endtask

    // style 0 full, 1 small, 2 flat, 3 repeated shapelet, 4 inverted shapelet
    task automatic feed_row(input int slen, input int style, input bit noisy);
        logic signed [15:0] v, flat_v;
        flat_v = 16'($urandom);
        for (int k = 0; k < slen; k++) begin
            if (noisy && $urandom_range(0, 19) == 0)
                feed_sample(1'b0, 16'($urandom));
            case (style)
                0, 1:    v = pick_value(style);
                2:       v = flat_v;
                3:       v = shp_vals[k % cur_len];
                default: v = -shp_vals[k % cur_len];
            endcase
            feed_sample(1'b1, v);
        end
    endtask

    task automatic set_lengths(input int shl, input int sel);
        write_reg(REG_SHAPELET_LENGTH, shl);
        write_reg(REG_SERIES_LENGTH, sel);
        cur_len = (shl == 0) ? 1 : (shl > MAX_SHAPELET_DEF) ? MAX_SHAPELET_DEF : shl;
        phase_cnt++;
    endtask

    initial begin
        int len, slen, nrows, pick;
        start       = 1'b0;
        i_func      = 1'b0;
        i_sample    = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_SHAPELET_LENGTH;
        i_cfg_data  = '0;
        idle_pct    = 0;
        beats_sent  = 0;
        phase_cnt   = 0;
        cur_len     = 1;
        i_rst_n     = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, perfect and anti correlation, flat cases
        set_lengths(2, 4);
        feed_sample(1'b0, 16'sh7FFF);
        feed_sample(1'b0, -16'sh8000);
        shp_vals[0] = 16'sh7FFF;
        shp_vals[1] = -16'sh8000;
        feed_row(4, 3, 1'b0);
        feed_sample(1'b1, -16'sh8000);
        feed_sample(1'b1, 16'sh7FFF);
        feed_sample(1'b1, 16'sh0000);
        feed_sample(1'b1, 16'sh0001);
        feed_row(4, 2, 1'b0);
        // flat shapelet
        feed_sample(1'b0, 16'sh0007);
        feed_sample(1'b0, 16'sh0007);
        feed_row(4, 0, 1'b0);
        // sample after a full shapelet restarts it, leaving it short
        feed_sample(1'b0, 16'sh0003);
        feed_row(4, 1, 1'b0);
        // shapelet longer than series
        set_lengths(8, 4);
        feed_row(4, 0, 1'b0);

        // random phases, small sizes; sender gap rate rotates per phase
        while (beats_sent < 400) begin
            case (phase_cnt % 4)
                0: idle_pct = 0;
                1: idle_pct = 71;
                2: idle_pct = 0;
                default: idle_pct = 26;
            endcase
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
            slen = len + $urandom_range(0, 8) - 1;
            if (slen < 1) slen = 1;
            set_lengths(len, slen);
            pick = $urandom_range(0, 9);
            if (pick == 0 && len > 1) load_shapelet(len - 1, 0);
            else if (pick == 1) load_shapelet(len + $urandom_range(1, 2), 0);
            else if (pick == 2) load_shapelet(len, 2);
            else load_shapelet(len, $urandom_range(0, 1));
            nrows = $urandom_range(2, 5);
            for (int r = 0; r < nrows; r++) begin
                feed_row(slen, $urandom_range(0, 4), $urandom_range(0, 3) == 0);
                if (r == 0 && phase_cnt % 5 == 0) drain();
            end
        end

        // register extremes: zero lengths clamp to one, an oversize shapelet
        // length clamps to the store depth and leaves no window
        idle_pct = 0;
        set_lengths(0, 0);
        feed_sample(1'b0, 16'($urandom));
        feed_row(1, 0, 1'b0);
        feed_row(1, 0, 1'b0);
        set_lengths(511, 4);
        feed_row(4, 0, 1'b0);

        drain();
        repeat (200) @(posedge i_clk);
        $display("Covered %0d item beats over %0d length settings, %0d row results checked.",
                 beats_sent, phase_cnt, rows_seen);
        if (errors == 0 && pending == 0) begin
            $display("[min_znorm_shapelet_distance] OK");
        end else begin
            $display("[min_znorm_shapelet_distance] ERROR");
        end
        $finish;
    end

endmodule
